FILE: rtl/pbvso_pkg.sv
// Shared constants and types for the band-limited variable-shape oscillator.
// Used by the top level and by the serial divider; depends on nothing else.
package pbvso_pkg;

  // Default phase accumulator width.
  localparam int PHASE_BITS_DEF = 24;

  // Fraction bits of all wave values, and the widths of the datapath.
  localparam int VF = 24;
  localparam int VW = 27;
  localparam int QW = 26;
  localparam int AW = 32;

  // One in Q.24 and the constant term of the integrated BLEP (0.1875).
  localparam logic signed [VW-1:0] ONE_V  = 27'sd16777216;
  localparam logic signed [VW-1:0] IBLEP_C = 27'sd3145728;

  // Result of the serial divider.
  typedef struct packed {
    logic          done;
    logic [QW-1:0] quot;
  } div_rsp_t;

endpackage

FILE: rtl/pbvso_div.sv
// Restoring serial divider, one quotient bit per cycle, num * 2^24 / den.
// Depends on pbvso_pkg. The caller guarantees den > 0 and num < 4 * den.
module pbvso_div #(
  parameter int DW = pbvso_pkg::PHASE_BITS_DEF + 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [DW-1:0]        num,
  input  logic [DW-1:0]        den,
  output pbvso_pkg::div_rsp_t  rsp
);
  import pbvso_pkg::*;

  localparam int CW = $clog2(QW);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] den_r;
  logic [1:0]    nb_r;
  logic [QW-1:0] quo_r;

  logic          bit_in;
  logic [DW:0]   trial;
  logic          ge;

  // The dividend is num followed by VF zero bits; only its two low num bits
  // enter after the initial load.
  always_comb begin
    if (cnt_r == CW'(QW - 1)) begin
      bit_in = nb_r[1];
    end else if (cnt_r == CW'(QW - 2)) begin
      bit_in = nb_r[0];
    end else begin
      bit_in = 1'b0;
    end
    trial = {rem_r, bit_in};
    ge    = (trial >= {1'b0, den_r});
  end

  // Iteration control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(QW - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  // Remainder and quotient shift registers.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num >> 2;
      nb_r  <= num[1:0];
      den_r <= den;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? DW'(trial - {1'b0, den_r}) : DW'(trial);
      quo_r <= {quo_r[QW-2:0], ge};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;

endmodule

FILE: rtl/polyblep_variable_shape_oscillator.sv
// Band-limited variable-shape oscillator with hard sync: top level and sequencer.
// Depends on pbvso_pkg and pbvso_div.
//
// Each input transfer is one audio sample tick; one output transfer follows
// with the sample. The block works on one tick at a time with one shared
// 27-bit signed multiplier and one serial divider; a divide whose result
// follows from its operands alone does not use the divider. A tick with no
// wave edge takes three divides and three products. Every edge of the slave
// wave adds one divide and ten products, and a master sync event adds two
// divides and eight products, so the longest tick is a sync with a rising
// and a falling edge. A new tick is taken while the previous sample waits
// at the output register; a finished tick stalls until that sample has
// been transferred. The sync_enable register is written through cfg_we
// and cfg_wdata and resets to 1.
module polyblep_variable_shape_oscillator #(
  parameter int PHASE_BITS = pbvso_pkg::PHASE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic                   cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [PHASE_BITS-1:0]  in_master_increment,
  input  logic [PHASE_BITS-1:0]  in_slave_increment,
  input  logic [PHASE_BITS-1:0]  in_pulse_width,
  input  logic [16:0]            in_shape,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [23:0]     out_sample
);
  import pbvso_pkg::*;

  localparam int P   = PHASE_BITS;
  localparam int MBW = (P + 2 > VW) ? P + 2 : VW;
  localparam int PW  = VW + MBW;
  localparam int SHR = (P >= VF) ? P - VF : 0;
  localparam int SHL = (P >= VF) ? 0 : VF - P;

  localparam logic [P-1:0] QUARTER = {2'b01, {(P-2){1'b0}}};
  localparam logic [P-1:0] HALF    = {2'b10, {(P-2){1'b0}}};
  localparam logic [P:0]   ONE_P   = {1'b1, {P{1'b0}}};

  // Sequencer states.
  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_RA    = 5'd1;
  localparam logic [4:0] S_RB    = 5'd2;
  localparam logic [4:0] S_STEP  = 5'd3;
  localparam logic [4:0] S_SYNC  = 5'd4;
  localparam logic [4:0] S_RT    = 5'd5;
  localparam logic [4:0] S_SPR   = 5'd6;
  localparam logic [4:0] S_LSET  = 5'd7;
  localparam logic [4:0] S_LLOW  = 5'd8;
  localparam logic [4:0] S_TRISE = 5'd9;
  localparam logic [4:0] S_LHIGH = 5'd10;
  localparam logic [4:0] S_TFALL = 5'd11;
  localparam logic [4:0] S_E_BT  = 5'd12;
  localparam logic [4:0] S_E_BN  = 5'd13;
  localparam logic [4:0] S_E_AT  = 5'd14;
  localparam logic [4:0] S_E_AN  = 5'd15;
  localparam logic [4:0] S_E_I1  = 5'd16;
  localparam logic [4:0] S_E_I2  = 5'd17;
  localparam logic [4:0] S_E_I3  = 5'd18;
  localparam logic [4:0] S_E_I4  = 5'd19;
  localparam logic [4:0] S_E_ST  = 5'd20;
  localparam logic [4:0] S_E_SN  = 5'd21;
  localparam logic [4:0] S_N_DIV = 5'd22;
  localparam logic [4:0] S_N_SQ  = 5'd23;
  localparam logic [4:0] S_N_TA  = 5'd24;
  localparam logic [4:0] S_FIN   = 5'd25;
  localparam logic [4:0] S_FRST  = 5'd26;
  localparam logic [4:0] S_OUT   = 5'd27;

  // Kinds of edge correction.
  localparam logic [1:0] EK_SYNC = 2'd0;
  localparam logic [1:0] EK_RISE = 2'd1;
  localparam logic [1:0] EK_FALL = 2'd2;

  // Sequencer and state registers.
  logic [4:0]             state_r;
  logic                   ph_r;
  logic                   sync_en_r;
  logic [P-1:0]           master_r;
  logic [P-1:0]           slave_r;
  logic signed [25:0]     carried_r;
  logic [P-1:0]           lastpw_r;
  logic                   oh_r;
  logic                   out_valid_r;
  logic signed [23:0]     out_sample_r;

  // Per-tick working registers.
  logic [P-1:0]           mf_r;
  logic [P-1:0]           f_r;
  logic [P-1:0]           pw_r;
  logic signed [VW-1:0]   sq_r;
  logic signed [VW-1:0]   ta_r;
  logic signed [VW-1:0]   ra_r;
  logic signed [VW-1:0]   step_r;
  logic signed [AW-1:0]   ths_r;
  logic signed [AW-1:0]   nxt_r;
  logic signed [VW-1:0]   rt_r;
  logic signed [VW-1:0]   t_r;
  logic [P:0]             sp_r;
  logic                   reset_r;
  logic                   trans_r;
  logic [2:0]             iter_r;
  logic [1:0]             ekind_r;
  logic signed [VW-1:0]   coef_r;
  logic signed [VW-1:0]   bt_r;
  logic signed [VW-1:0]   bn_r;
  logic signed [VW-1:0]   t2_r;
  logic signed [VW-1:0]   in_r;
  logic signed [VW-1:0]   it_r;
  logic [P-1:0]           nph_r;
  logic                   nret_r;
  logic                   nsq_r;
  logic signed [VW-1:0]   ntri_r;
  logic signed [VW-1:0]   nv_r;
  logic signed [PW-1:0]   prod_r;

  // Input conditioning.
  logic [P-1:0]           mf_c;
  logic [P-1:0]           f_c;
  logic [P-1:0]           pw_c;
  logic [P:0]             lo_c;
  logic [P:0]             hi_c;
  logic [P:0]             pwx_c;
  logic [16:0]            s_c;
  logic [17:0]            tt_c;
  logic signed [VW-1:0]   sq_c;
  logic signed [VW-1:0]   ta_c;

  always_comb begin
    mf_c  = (in_master_increment >= QUARTER) ? QUARTER : in_master_increment;
    lo_c  = {in_slave_increment, 1'b0};
    hi_c  = ONE_P - lo_c;
    pwx_c = {1'b0, in_pulse_width};
    if (in_slave_increment >= QUARTER) begin
      f_c  = QUARTER;
      pw_c = HALF;
    end else begin
      f_c = in_slave_increment;
      if (pwx_c < lo_c) begin
        pwx_c = lo_c;
      end
      if (pwx_c > hi_c) begin
        pwx_c = hi_c;
      end
      pw_c = pwx_c[P-1:0];
    end
    s_c  = (in_shape > 17'd65536) ? 17'd65536 : in_shape;
    tt_c = 18'd65536 - {s_c, 1'b0};
    sq_c = (s_c > 17'd32768) ? $signed(VW'({s_c - 17'd32768, 9'b0})) : '0;
    ta_c = ({s_c, 1'b0} < 18'd65536) ? $signed(VW'({tt_c, 8'b0})) : '0;
  end

  // Shared multiplier operand selection.
  logic signed [VW-1:0]   mul_a;
  logic signed [MBW-1:0]  mul_b;
  logic signed [MBW-1:0]  f_ext;
  logic signed [VW-1:0]   u_c;
  logic signed [VW-1:0]   t1_c;
  logic signed [VW-1:0]   u1_c;
  logic signed [VW-1:0]   nsa_c;
  logic signed [VW-1:0]   nta_c;

  always_comb begin
    f_ext = $signed({{(MBW-P){1'b0}}, f_r});
    u_c   = ONE_V - t_r;
    t1_c  = t_r >>> 1;
    u1_c  = u_c >>> 1;
    nsa_c = (nsq_r ? ONE_V : '0) - nv_r;
    nta_c = ntri_r - nv_r;
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_STEP: begin mul_a = ra_r;           mul_b = MBW'(ta_r);   end
      S_SPR:  begin mul_a = ONE_V - rt_r;   mul_b = f_ext;        end
      S_FRST: begin mul_a = rt_r;           mul_b = f_ext;        end
      S_E_BT: begin mul_a = t_r;            mul_b = MBW'(t_r);    end
      S_E_BN: begin mul_a = u_c;            mul_b = MBW'(u_c);    end
      S_E_AT: begin mul_a = coef_r;         mul_b = MBW'(bt_r);   end
      S_E_AN: begin mul_a = coef_r;         mul_b = MBW'(bn_r);   end
      S_E_I1: begin mul_a = t1_c;           mul_b = MBW'(t1_c);   end
      S_E_I2: begin mul_a = t2_r;           mul_b = MBW'(t2_r);   end
      S_E_I3: begin mul_a = u1_c;           mul_b = MBW'(u1_c);   end
      S_E_I4: begin mul_a = t2_r;           mul_b = MBW'(t2_r);   end
      S_E_ST: begin mul_a = step_r;         mul_b = MBW'(it_r);   end
      S_E_SN: begin mul_a = step_r;         mul_b = MBW'(in_r);   end
      S_N_SQ: begin mul_a = nsa_c;          mul_b = MBW'(sq_r);   end
      S_N_TA: begin mul_a = nta_c;          mul_b = MBW'(ta_r);   end
      default: begin mul_a = '0;            mul_b = '0;           end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // Product views: floor of product / 2^24, and of product / 2^25.
  logic signed [PW-1:0]   p24_w;
  logic signed [PW-1:0]   p25_w;
  logic signed [AW-1:0]   p24_a;
  logic signed [VW-1:0]   p24_v;
  logic signed [VW-1:0]   p25_v;
  logic signed [VW-1:0]   ib_t1;
  logic signed [VW-1:0]   ib_c;

  always_comb begin
    p24_w = prod_r >>> VF;
    p25_w = prod_r >>> (VF + 1);
    p24_a = p24_w[AW-1:0];
    p24_v = p24_w[VW-1:0];
    p25_v = p25_w[VW-1:0];
    ib_t1 = (state_r == S_E_I2) ? t1_c : u1_c;
    ib_c  = IBLEP_C - ib_t1 + ((t2_r + (t2_r <<< 1)) >>> 1) - p24_v;
  end

  // Divider operand selection and saturation of crossing times.
  logic [P:0]             div_num;
  logic signed [P+1:0]    div_den;
  logic                   div_sat;
  logic                   n_lt;
  logic                   div_state;
  logic                   spec;
  logic signed [VW-1:0]   spec_val;
  logic                   div_start;
  logic                   div_fire;
  logic signed [VW-1:0]   dq_c;
  pbvso_pkg::div_rsp_t    rsp;

  always_comb begin
    n_lt    = (nph_r < pw_r);
    div_num = {1'b0, f_r};
    div_den = $signed({2'b00, pw_r});
    div_sat = 1'b0;
    case (state_r)
      S_RA: begin
        div_num = {1'b0, f_r};
        div_den = $signed({2'b00, pw_r});
      end
      S_RB: begin
        div_num = {1'b0, f_r};
        div_den = $signed({1'b0, ONE_P - {1'b0, pw_r}});
      end
      S_RT: begin
        div_num = {1'b0, master_r};
        div_den = $signed({2'b00, mf_r});
        div_sat = 1'b1;
      end
      S_TRISE: begin
        div_num = sp_r - {1'b0, pw_r};
        div_den = $signed({2'b00, lastpw_r}) - $signed({2'b00, pw_r})
                  + $signed({2'b00, f_r});
        div_sat = 1'b1;
      end
      S_TFALL: begin
        div_num = sp_r;
        div_den = $signed({2'b00, f_r});
        div_sat = 1'b1;
      end
      S_N_DIV: begin
        div_num = n_lt ? {1'b0, nph_r} : {1'b0, nph_r - pw_r};
        div_den = n_lt ? $signed({2'b00, pw_r})
                       : $signed({1'b0, ONE_P - {1'b0, pw_r}});
      end
      default: begin
        div_num = {1'b0, f_r};
        div_den = $signed({2'b00, pw_r});
      end
    endcase

    div_state = (state_r == S_RA) || (state_r == S_RB) || (state_r == S_RT) ||
                (state_r == S_TRISE) || (state_r == S_TFALL) ||
                (state_r == S_N_DIV);

    // Zero divisors, negative crossing-time divisors and quotients that must saturate skip the divider.
    if (div_sat) begin
      if (div_den <= 0) begin
        spec     = 1'b1;
        spec_val = ((div_den == 0) && (div_num != '0)) ? ONE_V : '0;
      end else if ({1'b0, div_num} >= {div_den[P:0], 1'b0}) begin
        spec     = 1'b1;
        spec_val = ONE_V;
      end else begin
        spec     = 1'b0;
        spec_val = '0;
      end
    end else begin
      spec     = (div_den == 0);
      spec_val = '0;
    end

    div_start = div_state && !ph_r && !spec;
    div_fire  = div_state && ((!ph_r && spec) || (ph_r && rsp.done));
    if (spec) begin
      dq_c = spec_val;
    end else if (rsp.quot > QW'(ONE_V)) begin
      dq_c = ONE_V;
    end else begin
      dq_c = $signed(VW'(rsp.quot));
    end
  end

  pbvso_div #(
    .DW (P + 1)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den[P:0]),
    .rsp   (rsp)
  );

  // Naive wave helpers: phase to Q.24, updated value after each blend.
  logic signed [VW-1:0]   tov_c;
  logic signed [VW-1:0]   nv_ta_c;
  logic [P:0]             mp_c;
  logic [P:0]             spr_c;
  logic                   trans_c;
  logic [P-1:0]           srst_c;
  logic signed [AW-1:0]   vout_c;
  logic signed [AW-1:0]   nxt_fin_c;

  always_comb begin
    tov_c   = $signed(VW'((nph_r >> SHR) << SHL));
    nv_ta_c = nv_r + p24_v;
    mp_c    = {1'b0, master_r} + {1'b0, mf_r};
    spr_c   = {1'b0, slave_r} + {1'b0, p24_w[P-1:0]};
    trans_c = trans_r;
    if (spr_c >= ONE_P) begin
      spr_c   = spr_c - ONE_P;
      trans_c = 1'b1;
    end
    if (!oh_r && (spr_c[P-1:0] >= pw_r)) begin
      trans_c = 1'b1;
    end
    srst_c    = p24_w[P-1:0];
    vout_c    = ths_r - 32'sd8388608;
    nxt_fin_c = nxt_r;
  end

  // The output step loads a new sample once the output register is free.
  logic                   out_load;

  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ready);

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_en_r <= 1'b1;
    end else if (cfg_we) begin
      sync_en_r <= cfg_wdata;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ph_r        <= 1'b0;
      master_r    <= '0;
      slave_r     <= '0;
      carried_r   <= '0;
      lastpw_r    <= HALF;
      oh_r        <= 1'b0;
      out_valid_r <= 1'b0;
      reset_r     <= 1'b0;
      trans_r     <= 1'b0;
      iter_r      <= '0;
    end else begin
      if (out_valid_r && out_ready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            mf_r    <= mf_c;
            f_r     <= f_c;
            pw_r    <= pw_c;
            sq_r    <= sq_c;
            ta_r    <= ta_c;
            ths_r   <= AW'(carried_r);
            nxt_r   <= '0;
            reset_r <= 1'b0;
            trans_r <= 1'b0;
            ph_r    <= 1'b0;
            state_r <= S_RA;
          end
        end
        S_RA, S_RB, S_RT, S_TRISE, S_TFALL, S_N_DIV: begin
          if (div_start) begin
            ph_r <= 1'b1;
          end
          if (div_fire) begin
            ph_r <= 1'b0;
            case (state_r)
              S_RA: begin
                ra_r    <= dq_c;
                state_r <= S_RB;
              end
              S_RB: begin
                ra_r    <= ra_r + dq_c;
                state_r <= S_STEP;
              end
              S_RT: begin
                rt_r    <= dq_c;
                state_r <= S_SPR;
              end
              S_TRISE: begin
                t_r     <= dq_c;
                coef_r  <= sq_r;
                ekind_r <= EK_RISE;
                state_r <= S_E_BT;
              end
              S_TFALL: begin
                t_r     <= dq_c;
                coef_r  <= ONE_V - ta_r;
                ekind_r <= EK_FALL;
                state_r <= S_E_BT;
              end
              default: begin
                nsq_r   <= !n_lt;
                ntri_r  <= n_lt ? dq_c : ONE_V - dq_c;
                nv_r    <= tov_c;
                state_r <= S_N_SQ;
              end
            endcase
          end
        end
        S_SYNC: begin
          if (sync_en_r) begin
            if (mp_c >= ONE_P) begin
              master_r <= P'(mp_c - ONE_P);
              reset_r  <= 1'b1;
              state_r  <= S_RT;
            end else begin
              master_r <= mp_c[P-1:0];
              state_r  <= S_LSET;
            end
          end else begin
            state_r <= S_LSET;
          end
        end
        S_LSET: begin
          sp_r   <= {1'b0, slave_r} + {1'b0, f_r};
          iter_r <= '0;
          state_r <= (trans_r || !reset_r) ? S_LLOW : S_FIN;
        end
        S_LLOW: begin
          if (iter_r == 3'd4) begin
            state_r <= S_FIN;
          end else if (oh_r) begin
            state_r <= S_LHIGH;
          end else if (sp_r < {1'b0, pw_r}) begin
            state_r <= S_FIN;
          end else begin
            state_r <= S_TRISE;
          end
        end
        S_LHIGH: begin
          if (sp_r < ONE_P) begin
            state_r <= S_FIN;
          end else begin
            sp_r    <= sp_r - ONE_P;
            state_r <= S_TFALL;
          end
        end
        S_FIN: begin
          if (reset_r) begin
            state_r <= S_FRST;
          end else begin
            slave_r <= sp_r[P-1:0];
            nph_r   <= sp_r[P-1:0];
            nret_r  <= 1'b1;
            state_r <= S_N_DIV;
          end
        end
        S_OUT: begin
          if (out_load) begin
            if (nxt_fin_c > 32'sd33554431) begin
              carried_r <= 26'sd33554431;
            end else if (nxt_fin_c < -32'sd33554432) begin
              carried_r <= -26'sd33554432;
            end else begin
              carried_r <= nxt_fin_c[25:0];
            end
            if (vout_c > 32'sd8388607) begin
              out_sample_r <= 24'sd8388607;
            end else if (vout_c < -32'sd8388608) begin
              out_sample_r <= -24'sd8388608;
            end else begin
              out_sample_r <= vout_c[23:0];
            end
            out_valid_r <= 1'b1;
            lastpw_r    <= pw_r;
            reset_r     <= 1'b0;
            trans_r     <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          // Multiply steps: the first phase loads the product register.
          ph_r <= !ph_r;
          if (ph_r) begin
            case (state_r)
              S_STEP: begin
                step_r  <= p24_v;
                state_r <= S_SYNC;
              end
              S_SPR: begin
                nph_r   <= spr_c[P-1:0];
                trans_r <= trans_c;
                nret_r  <= 1'b0;
                state_r <= S_N_DIV;
              end
              S_FRST: begin
                slave_r <= srst_c;
                nph_r   <= srst_c;
                oh_r    <= 1'b0;
                nret_r  <= 1'b1;
                state_r <= S_N_DIV;
              end
              S_E_BT: begin
                bt_r    <= p25_v;
                state_r <= S_E_BN;
              end
              S_E_BN: begin
                bn_r    <= -p25_v;
                state_r <= S_E_AT;
              end
              S_E_AT: begin
                ths_r   <= (ekind_r == EK_RISE) ? ths_r + p24_a : ths_r - p24_a;
                state_r <= S_E_AN;
              end
              S_E_AN: begin
                nxt_r <= (ekind_r == EK_RISE) ? nxt_r + p24_a : nxt_r - p24_a;
                state_r <= (ekind_r == EK_SYNC) ? S_LSET : S_E_I1;
              end
              S_E_I1: begin
                t2_r    <= p24_v;
                state_r <= S_E_I2;
              end
              S_E_I2: begin
                in_r    <= ib_c;
                state_r <= S_E_I3;
              end
              S_E_I3: begin
                t2_r    <= p24_v;
                state_r <= S_E_I4;
              end
              S_E_I4: begin
                it_r    <= ib_c;
                state_r <= S_E_ST;
              end
              S_E_ST: begin
                ths_r   <= (ekind_r == EK_RISE) ? ths_r - p24_a : ths_r + p24_a;
                state_r <= S_E_SN;
              end
              S_E_SN: begin
                nxt_r <= (ekind_r == EK_RISE) ? nxt_r - p24_a : nxt_r + p24_a;
                if (ekind_r == EK_RISE) begin
                  oh_r    <= 1'b1;
                  state_r <= S_LHIGH;
                end else begin
                  oh_r    <= 1'b0;
                  iter_r  <= iter_r + 1'b1;
                  state_r <= S_LLOW;
                end
              end
              S_N_SQ: begin
                nv_r    <= nv_r + p24_v;
                state_r <= S_N_TA;
              end
              S_N_TA: begin
                if (nret_r) begin
                  nxt_r   <= nxt_r + AW'(nv_ta_c);
                  state_r <= S_OUT;
                end else begin
                  coef_r  <= nv_ta_c;
                  t_r     <= rt_r;
                  ekind_r <= EK_SYNC;
                  state_r <= S_E_BT;
                end
              end
              default: begin
                state_r <= S_IDLE;
              end
            endcase
          end
        end
      endcase
    end
  end

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;

  // A transfer in always starts the first ratio divide in its first phase.
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> (state_r == S_RA) && !ph_r)
    else $error("tick did not start with the first divide");

  // The crossing loop never runs more than four passes.
  a_iter: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LLOW) |-> (iter_r <= 3'd4))
    else $error("crossing loop ran past four passes");

  // A quotient only arrives while a divide step waits for it.
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |-> ph_r && div_state)
    else $error("divider finished with no divide step waiting");

  // A new sample appears only out of the output step.
  a_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_OUT))
    else $error("sample presented outside the output step");

endmodule

FILE: tb/sv/pbvso_checker.sv
// Scoreboard for the band-limited variable-shape oscillator: it watches both channels
// and the sync_enable write port, predicts each sample and compares it with the block.
// Depends on nothing but the port signals of polyblep_variable_shape_oscillator.
module pbvso_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [23:0]        in_master_increment,
  input  logic [23:0]        in_slave_increment,
  input  logic [23:0]        in_pulse_width,
  input  logic [16:0]        in_shape,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [23:0] out_sample,
  output int                 pending,
  output int                 errors,
  output int                 checked
);

  localparam longint      ONE_Q = 64'sd16777216;
  localparam logic [63:0] CYCLE = 64'h1000000;
  localparam logic [63:0] PMASK = 64'hFFFFFF;

  // Oscillator state mirrored from the block.
  logic        sync_on;
  logic [63:0] master_ph;
  logic [63:0] slave_ph;
  longint      carry_next;
  logic [63:0] prev_pw;
  logic        wave_high;

  logic signed [23:0] expected_samples[$];

  // Product of two Q.24 values, rounded toward minus infinity.
  function automatic longint mul_q24(longint a, longint b);
    longint p;
    p = a * b;
    if (p >= 0) return p >>> 24;
    return -((-p + ONE_Q - 1) >>> 24);
  endfunction

  // Quotient as Q.24; a zero divisor gives 0.
  function automatic longint frac_div(logic [63:0] num, logic [63:0] den);
    if (den == 0) return 0;
    return longint'((num << 24) / den);
  endfunction

  // Sub-sample crossing time, saturated into [0,1].
  function automatic longint cross_time(logic [63:0] num, longint den);
    logic [63:0] q;
    if (den <= 0) return (den == 0 && num > 0) ? ONE_Q : 0;
    q = (num << 24) / $unsigned(den);
    return (q > ONE_Q) ? ONE_Q : longint'(q);
  endfunction

  function automatic longint blep_now(longint t);
    return (t * t) >>> 25;
  endfunction

  function automatic longint blep_after(longint t);
    longint u;
    u = ONE_Q - t;
    return -((u * u) >>> 25);
  endfunction

  function automatic longint iblep_after(longint t);
    longint t1, t2, t4;
    t1 = t >>> 1;
    t2 = (t1 * t1) >>> 24;
    t4 = (t2 * t2) >>> 24;
    return (64'sd3 <<< 20) - t1 + ((3 * t2) >>> 1) - t4;
  endfunction

  function automatic longint iblep_now(longint t);
    return iblep_after(ONE_Q - t);
  endfunction

  // Unsmoothed wave at one phase: ramp blended toward square, then toward triangle.
  function automatic longint wave_at(logic [63:0] ph, logic [63:0] pw, longint ta,
                                     longint sq);
    longint v, square, tri_val;
    v = longint'(ph);
    if (ph < pw) begin
      square = 0;
      tri_val = frac_div(ph, pw);
    end else begin
      square = ONE_Q;
      tri_val = ONE_Q - frac_div(ph - pw, CYCLE - pw);
    end
    v += mul_q24(square - v, sq);
    v += mul_q24(tri_val - v, ta);
    return v;
  endfunction

  // Advances the oscillator by one tick and returns the sample it emits.
  function automatic logic signed [23:0] predict_tick(logic [63:0] mf, logic [63:0] f,
                                                      logic [63:0] pw, logic [63:0] s);
    logic [63:0] quarter, spr, sp;
    longint sq, ta, slope, t, rt, now_sum, next_sum, v, val;
    logic synced, edge_hit, stop;
    quarter = CYCLE >> 2;
    rt = 0;
    next_sum = 0;
    synced = 1'b0;
    edge_hit = 1'b0;
    stop = 1'b0;
    if (mf >= quarter) mf = quarter;
    if (f >= quarter) f = quarter;
    if (f >= quarter) begin
      pw = CYCLE >> 1;
    end else begin
      if (pw < 2 * f) pw = 2 * f;
      if (pw > CYCLE - 2 * f) pw = CYCLE - 2 * f;
    end
    if (s > 65536) s = 65536;
    sq = (s > 32768) ? longint'((s - 32768) * 2) <<< 8 : 0;
    ta = (2 * s < 65536) ? longint'(65536 - 2 * s) <<< 8 : 0;
    slope = mul_q24(frac_div(f, pw) + frac_div(f, CYCLE - pw), ta);
    now_sum = carry_next;

    // Hard sync at the master wrap, with a step correction for the jump.
    if (sync_on) begin
      master_ph += mf;
      if (master_ph >= CYCLE) begin
        master_ph -= CYCLE;
        rt = cross_time(master_ph, longint'(mf));
        spr = slave_ph + (($unsigned(ONE_Q - rt) * f) >> 24);
        synced = 1'b1;
        if (spr >= CYCLE) begin
          spr -= CYCLE;
          edge_hit = 1'b1;
        end
        if (!wave_high && spr >= pw) edge_hit = 1'b1;
        val = wave_at(spr, pw, ta, sq);
        now_sum -= mul_q24(val, blep_now(rt));
        next_sum -= mul_q24(val, blep_after(rt));
      end
    end

    // Walk the pulse-width and wrap edges that fall inside this tick.
    sp = slave_ph + f;
    if (edge_hit || !synced) begin
      for (int k = 0; k < 4 && !stop; k++) begin
        if (!wave_high) begin
          if (sp < pw) begin
            stop = 1'b1;
          end else begin
            t = cross_time(sp - pw, longint'(prev_pw) - longint'(pw) + longint'(f));
            now_sum += mul_q24(sq, blep_now(t));
            next_sum += mul_q24(sq, blep_after(t));
            now_sum -= mul_q24(slope, iblep_now(t));
            next_sum -= mul_q24(slope, iblep_after(t));
            wave_high = 1'b1;
          end
        end
        if (!stop && wave_high) begin
          if (sp < CYCLE) begin
            stop = 1'b1;
          end else begin
            sp -= CYCLE;
            t = cross_time(sp, longint'(f));
            now_sum -= mul_q24(ONE_Q - ta, blep_now(t));
            next_sum -= mul_q24(ONE_Q - ta, blep_after(t));
            now_sum += mul_q24(slope, iblep_now(t));
            next_sum += mul_q24(slope, iblep_after(t));
            wave_high = 1'b0;
          end
        end
      end
    end
    sp &= PMASK;
    if (synced) begin
      sp = (($unsigned(rt) * f) >> 24) & PMASK;
      wave_high = 1'b0;
    end
    slave_ph = sp;
    next_sum += wave_at(sp, pw, ta, sq);
    prev_pw = pw;
    if (next_sum > (64'sd1 <<< 25) - 1) next_sum = (64'sd1 <<< 25) - 1;
    if (next_sum < -(64'sd1 <<< 25)) next_sum = -(64'sd1 <<< 25);
    carry_next = next_sum;

    v = now_sum - (64'sd1 <<< 23);
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return v[23:0];
  endfunction

  assign pending = expected_samples.size();

  // Predict on each input transfer, compare on each output transfer.
  always @(posedge clk) begin
    logic signed [23:0] exp_s;
    if (!rst_n) begin
      sync_on = 1'b1;
      master_ph = 0;
      slave_ph = 0;
      carry_next = 0;
      prev_pw = CYCLE >> 1;
      wave_high = 1'b0;
      errors = 0;
      checked = 0;
      expected_samples.delete();
    end else begin
      if (cfg_we) sync_on = cfg_wdata;
      if (in_valid && in_ready)
        expected_samples.push_back(predict_tick(in_master_increment, in_slave_increment,
                                                in_pulse_width, in_shape));
      if (out_valid && out_ready) begin
        if (expected_samples.size() == 0) begin
          $error("sample transfer with no expected value: actual %0d", out_sample);
          errors++;
        end else begin
          exp_s = expected_samples.pop_front();
          checked++;
          if (exp_s !== out_sample) begin
            $error("sample mismatch: expected %0d, actual %0d", exp_s, out_sample);
            errors++;
          end
        end
      end
    end
  end

endmodule

FILE: tb/sv/testbench.sv
// Top of the oscillator testbench: clock, reset, stimulus, sync_enable writes and verdict.
// Depends on polyblep_variable_shape_oscillator and the pbvso_checker scoreboard.
module testbench;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic               cfg_wdata = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [23:0]        in_master_increment = '0;
  logic [23:0]        in_slave_increment = '0;
  logic [23:0]        in_pulse_width = '0;
  logic [16:0]        in_shape = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [23:0] out_sample;

  int pending, errors, checked;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  polyblep_variable_shape_oscillator u_top (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_master_increment(in_master_increment), .in_slave_increment(in_slave_increment),
    .in_pulse_width(in_pulse_width), .in_shape(in_shape),
    .out_valid(out_valid), .out_ready(out_ready), .out_sample(out_sample)
  );

  pbvso_checker u_checker (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_master_increment(in_master_increment), .in_slave_increment(in_slave_increment),
    .in_pulse_width(in_pulse_width), .in_shape(in_shape),
    .out_valid(out_valid), .out_ready(out_ready), .out_sample(out_sample),
    .pending(pending), .errors(errors), .checked(checked)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // The receiver stalls at random at the current rate.
  always @(posedge clk) begin
    out_ready <= rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Presents one tick after random idle cycles and holds it until the transfer.
  task automatic send_tick(logic [23:0] mf, logic [23:0] f, logic [23:0] pw,
                           logic [16:0] s);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_master_increment <= mf;
    in_slave_increment <= f;
    in_pulse_width <= pw;
    in_shape <= s;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drains the block, then writes sync_enable while nothing is in flight.
  task automatic write_sync(logic value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [23:0] pick_increment();
    case ($urandom_range(0, 6))
      0: return 24'($urandom);
      1: return 24'($urandom_range(0, 24'h03FFFF));
      2: return 24'($urandom_range(0, 24'h400000));
      3: return 24'h400000;
      4: return 24'($urandom_range(24'h100000, 24'h3FFFFF));
      5: return 24'($urandom_range(0, 24'h000FFF));
      default: return 24'($urandom_range(24'h010000, 24'h200000));
    endcase
  endfunction

  function automatic logic [23:0] pick_width();
    case ($urandom_range(0, 3))
      0: return 24'($urandom);
      1: return 24'($urandom_range(0, 24'h100000));
      2: return 24'($urandom_range(24'hF00000, 24'hFFFFFF));
      default: return 24'($urandom_range(24'h600000, 24'hA00000));
    endcase
  endfunction

  function automatic logic [16:0] pick_shape();
    case ($urandom_range(0, 5))
      0: return 17'd0;
      1: return 17'd32768;
      2: return 17'd65536;
      3: return 17'($urandom);
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  // Mostly steady notes with occasional jumps, the way an oscillator is played.
  task automatic random_phase(int count);
    logic [23:0] mf, f, pw;
    logic [16:0] s;
    mf = pick_increment();
    f = pick_increment();
    pw = pick_width();
    s = pick_shape();
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0) mf = pick_increment();
      if ($urandom_range(0, 9) == 0) f = pick_increment();
      if ($urandom_range(0, 7) == 0) pw = pick_width();
      if ($urandom_range(0, 7) == 0) s = pick_shape();
      if ($urandom_range(0, 19) == 0)
        send_tick(24'($urandom), 24'($urandom), 24'($urandom), 17'($urandom));
      else
        send_tick(mf, f, pw, s);
    end
  endtask

  // Run limit.
  initial begin
    #40000000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes, each shape corner, zero and saturated frequencies.
    send_tick(24'h000000, 24'h000000, 24'h000000, 17'd0);
    send_tick(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 17'h1FFFF);
    send_tick(24'h400000, 24'h000000, 24'hFFFFFF, 17'd32768);
    send_tick(24'h400000, 24'h000000, 24'h000000, 17'd65536);
    send_tick(24'h3FFFFF, 24'h3FFFFF, 24'h000000, 17'd0);
    send_tick(24'h400000, 24'h400000, 24'h123456, 17'd65536);
    send_tick(24'h200000, 24'h300000, 24'h800000, 17'd16384);
    send_tick(24'h200000, 24'h300000, 24'h800000, 17'd49152);
    send_tick(24'h000001, 24'h000001, 24'h000001, 17'd1);
    send_tick(24'h3FFFFF, 24'h100000, 24'hFFFFFF, 17'd65535);
    send_tick(24'h3FFFFF, 24'h180000, 24'h400000, 17'd32767);
    send_tick(24'h555555, 24'hAAAAAA, 24'h555555, 17'h15555);
    send_tick(24'hAAAAAA, 24'h555555, 24'hAAAAAA, 17'h0AAAA);
    send_tick(24'h400000, 24'h200000, 24'h200000, 17'd65536);
    send_tick(24'h300000, 24'h010000, 24'h020000, 17'd0);
    send_tick(24'h000000, 24'h3FFFFF, 24'hFFFFFF, 17'd65537);
    write_sync(1'b0);
    send_tick(24'h400000, 24'h200000, 24'h900000, 17'd40000);
    send_tick(24'h400000, 24'h3FFFFF, 24'h100000, 17'd0);
    send_tick(24'h000000, 24'h000000, 24'h000000, 17'd65536);
    write_sync(1'b1);

    // Random phases with changing flow control and sync settings.
    send_idle_pct = 24;
    recv_idle_pct = 48;
    random_phase(270);
    write_sync(1'b0);
    send_idle_pct = 48;
    recv_idle_pct = 24;
    random_phase(270);
    write_sync(1'b1);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(270);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("Covered %0d checked samples over directed corners and three random phases,",
             checked);
    $display("with hard sync both on and off and varied valid and ready stalls.");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
